@@ rtl/pprs_pkg.sv @@
package pprs_pkg;

	localparam int NUM_POS   = 128;
	localparam int POS_BITS  = 7;
	localparam int CNT_BITS  = 16;
	localparam int SMP_BITS  = 32;
	localparam int SUM_BITS  = 63;
	localparam int DVD_BITS  = 64;
	localparam int STEP_BITS = 6;

	// action codes
	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_REM = 2'd1;
	localparam logic [1:0] ACT_REP = 2'd2;
	localparam logic [1:0] ACT_NOP = 2'd3;

	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	// one table entry
	typedef struct packed {
		logic [CNT_BITS-1:0]        cnt;
		logic signed [SMP_BITS-1:0] mean;
		logic [SUM_BITS-1:0]        m2;
		logic signed [SMP_BITS-1:0] mn;
		logic signed [SMP_BITS-1:0] mx;
		logic [CNT_BITS-1:0]        dcnt;
		logic                       num;
	} entry_t;

	// magnitude of a difference of two samples
	function automatic logic [SMP_BITS:0] mag33(input logic signed [SMP_BITS:0] a);
		mag33 = a[SMP_BITS] ? (SMP_BITS+1)'(0) - a : a;
	endfunction

endpackage

@@ rtl/per_position_running_stats.sv @@
// Running statistics table, 128 positions, one item at a time. Raise start while busy
// is low; busy stays high until the result beat, which shows on the result ports for
// exactly one cycle with done high and must be taken then, since it cannot be held off.
// All divides go through one shared restoring divider that retires one quotient bit a cycle:
// 33 steps for a mean update on add, 49 for a mean update on remove, 63 for the variance
// or 32 for the score. Busy covers the table read and decode, then the numeric add or the
// numeric remove (cut short when it empties the entry), both for a replace, then the
// result setup, 63 or 32 divide steps when a divide is needed, and write back; done
// follows in the next cycle.
module per_position_running_stats
	import pprs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [POS_BITS-1:0]        position,
	input  logic signed [SMP_BITS-1:0] new_value,
	input  logic                       new_is_numeric,
	input  logic signed [SMP_BITS-1:0] old_value,
	output logic                       done,
	output logic [POS_BITS-1:0]        entry_index,
	output logic [CNT_BITS-1:0]        sample_total,
	output logic signed [SMP_BITS-1:0] mean_out,
	output logic [SUM_BITS-1:0]        variance_out,
	output logic [SUM_BITS-1:0]        score_out,
	output logic signed [SMP_BITS-1:0] min_out,
	output logic signed [SMP_BITS-1:0] max_out,
	output logic                       numeric_out
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_OP,
		ST_ADD0, ST_ADD1, ST_ADIV, ST_ADD2, ST_ADD3, ST_ADD4,
		ST_REM0, ST_REM1, ST_RDIV, ST_REM2, ST_REM3, ST_REM4,
		ST_VAR, ST_ODIV, ST_WB
	} state_t;

	state_t state_q;

	entry_t mem [NUM_POS];
	entry_t rd_s1;
	logic   vld_s1;
	logic [NUM_POS-1:0] valid_q;

	// captured item
	logic [1:0]                 act_q;
	logic [POS_BITS-1:0]        pos_q;
	logic signed [SMP_BITS-1:0] xn_q;
	logic signed [SMP_BITS-1:0] xo_q;
	logic                       nin_q;
	logic                       rep_q;

	// working copy of the entry
	logic [CNT_BITS-1:0]        cnt_q;
	logic signed [SMP_BITS-1:0] mean_q;
	logic [SUM_BITS-1:0]        m2_q;
	logic signed [SMP_BITS-1:0] mn_q;
	logic signed [SMP_BITS-1:0] mx_q;
	logic [CNT_BITS-1:0]        dist_q;
	logic                       num_q;

	// datapath registers
	logic signed [SMP_BITS:0]     delta_q;
	logic signed [2*SMP_BITS:0]   mc_q;
	logic                         rneg_q;
	logic signed [SMP_BITS-1:0]   nm_q;
	logic [2*SMP_BITS+1:0]        prod_q;
	logic                         d2neg_q;
	logic                         d2nz_q;
	logic [SUM_BITS-1:0]          res_q;
	logic                         isvar_q;

	// divider
	logic [DVD_BITS-1:0]  dvd_q;
	logic [CNT_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]  dsr_q;
	logic [STEP_BITS-1:0] dstep_q;

	logic accept;
	logic wr_en;
	entry_t wdata;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign wr_en  = (state_q == ST_WB);

	always_comb begin
		wdata.cnt  = cnt_q;
		wdata.mean = mean_q;
		wdata.m2   = m2_q;
		wdata.mn   = mn_q;
		wdata.mx   = mx_q;
		wdata.dcnt = dist_q;
		wdata.num  = num_q;
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wdata;
		end
		if (accept) begin
			rd_s1 <= mem[position];
		end
	end

	// written marks, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= valid_q[position];
			end
			if (wr_en) begin
				valid_q[pos_q] <= 1'b1;
			end
		end
	end

	// divider step
	logic [CNT_BITS:0]   dv_t;
	logic                dv_ge;
	logic [CNT_BITS:0]   dv_sub;
	logic                dv_last;

	always_comb begin
		dv_t    = {rem_q, dvd_q[DVD_BITS-1]};
		dv_ge   = dv_t >= {1'b0, dsr_q};
		dv_sub  = dv_t - {1'b0, dsr_q};
		dv_last = (dstep_q == STEP_BITS'(1));
	end

	// combinational helpers
	logic signed [SMP_BITS+1:0]        add_q_s;
	logic signed [SMP_BITS+1:0]        add_mean;
	logic signed [SMP_BITS:0]          d2_add;
	logic signed [SMP_BITS:0]          d2_rem;
	logic signed [SMP_BITS+CNT_BITS:0] mc_w;
	logic signed [2*SMP_BITS+1:0]      rnum;
	logic [2*SMP_BITS:0]               rmag;
	logic signed [2*SMP_BITS+1:0]      nmw;
	logic [SMP_BITS+17:0]              pscaled;
	logic [SUM_BITS:0]                 m2_sum;
	logic [SUM_BITS-1:0]               m2_add;
	logic [SUM_BITS-1:0]               m2_sub;
	logic                              rem_grow;
	logic [CNT_BITS-1:0]               cnt_inc;
	logic [CNT_BITS-1:0]               dist_inc;

	always_comb begin
		add_q_s  = delta_q[SMP_BITS] ? -$signed({1'b0, dvd_q[SMP_BITS:0]})
		                             :  $signed({1'b0, dvd_q[SMP_BITS:0]});
		add_mean = (SMP_BITS+2)'(mean_q) + add_q_s;
		d2_add   = (SMP_BITS+1)'(xn_q) - (SMP_BITS+1)'(mean_q);
		d2_rem   = (SMP_BITS+1)'(xo_q) - (SMP_BITS+1)'(nm_q);
		mc_w     = mean_q * $signed({1'b0, cnt_q});
		rnum     = (2*SMP_BITS+2)'(mc_q) - (2*SMP_BITS+2)'(xo_q);
		rmag     = rnum[2*SMP_BITS+1] ? (2*SMP_BITS+1)'(-rnum) : (2*SMP_BITS+1)'(rnum);
		nmw      = rneg_q ? -$signed({2'b00, dvd_q})
		                  :  $signed({2'b00, dvd_q});
		pscaled  = prod_q[2*SMP_BITS+1:16];
		m2_sum   = {1'b0, m2_q} + (SUM_BITS+1)'(pscaled);
		m2_add   = m2_sum[SUM_BITS] ? {SUM_BITS{1'b1}} : m2_sum[SUM_BITS-1:0];
		m2_sub   = (m2_q > SUM_BITS'(pscaled)) ? m2_q - SUM_BITS'(pscaled) : '0;
		rem_grow = (delta_q[SMP_BITS] != d2neg_q) && (delta_q != '0) && d2nz_q;
		cnt_inc  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_BITS'(1);
		dist_inc = (dist_q == CNT_MAX) ? dist_q : dist_q + CNT_BITS'(1);
	end

	// sequencer, working registers and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_NOP;
			pos_q        <= '0;
			xn_q         <= '0;
			xo_q         <= '0;
			nin_q        <= 1'b0;
			rep_q        <= 1'b0;
			cnt_q        <= '0;
			mean_q       <= '0;
			m2_q         <= '0;
			mn_q         <= '0;
			mx_q         <= '0;
			dist_q       <= '0;
			num_q        <= 1'b0;
			delta_q      <= '0;
			mc_q         <= '0;
			rneg_q       <= 1'b0;
			nm_q         <= '0;
			prod_q       <= '0;
			d2neg_q      <= 1'b0;
			d2nz_q       <= 1'b0;
			res_q        <= '0;
			isvar_q      <= 1'b0;
			dvd_q        <= '0;
			rem_q        <= '0;
			dsr_q        <= '0;
			dstep_q      <= '0;
			done         <= 1'b0;
			entry_index  <= '0;
			sample_total <= '0;
			mean_out     <= '0;
			variance_out <= '0;
			score_out    <= '0;
			min_out      <= '0;
			max_out      <= '0;
			numeric_out  <= 1'b0;
		end else begin
			done <= 1'b0;

			// shared divider runs in the three divide states
			if (state_q == ST_ADIV || state_q == ST_RDIV || state_q == ST_ODIV) begin
				rem_q   <= dv_ge ? dv_sub[CNT_BITS-1:0] : dv_t[CNT_BITS-1:0];
				dvd_q   <= {dvd_q[DVD_BITS-2:0], dv_ge};
				dstep_q <= dstep_q - STEP_BITS'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q   <= action;
						pos_q   <= position;
						xn_q    <= new_is_numeric ? new_value : '0;
						xo_q    <= old_value;
						nin_q   <= new_is_numeric;
						rep_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= vld_s1 ? rd_s1.cnt  : '0;
					mean_q  <= vld_s1 ? rd_s1.mean : '0;
					m2_q    <= vld_s1 ? rd_s1.m2   : '0;
					mn_q    <= vld_s1 ? rd_s1.mn   : '0;
					mx_q    <= vld_s1 ? rd_s1.mx   : '0;
					dist_q  <= vld_s1 ? rd_s1.dcnt : '0;
					num_q   <= vld_s1 ? rd_s1.num  : 1'b0;
					state_q <= ST_OP;
				end
				ST_OP: begin
					unique case (act_q)
						ACT_ADD: begin
							if (num_q || nin_q) begin
								num_q   <= 1'b1;
								state_q <= ST_ADD0;
							end else begin
								cnt_q   <= cnt_inc;
								dist_q  <= dist_inc;
								state_q <= ST_VAR;
							end
						end
						ACT_REM: begin
							if (num_q) begin
								state_q <= ST_REM0;
							end else begin
								if (cnt_q != '0) cnt_q <= cnt_q - CNT_BITS'(1);
								if (dist_q != '0) dist_q <= dist_q - CNT_BITS'(1);
								state_q <= ST_VAR;
							end
						end
						ACT_REP: begin
							if (num_q && xn_q != xo_q) begin
								rep_q   <= 1'b1;
								state_q <= ST_REM0;
							end else begin
								state_q <= ST_VAR;
							end
						end
						default: begin
							state_q <= ST_VAR;
						end
					endcase
				end

				// welford add
				ST_ADD0: begin
					cnt_q   <= cnt_inc;
					delta_q <= (SMP_BITS+1)'(xn_q) - (SMP_BITS+1)'(mean_q);
					state_q <= ST_ADD1;
				end
				ST_ADD1: begin
					dvd_q   <= {mag33(delta_q), (DVD_BITS-SMP_BITS-1)'(0)};
					rem_q   <= '0;
					dsr_q   <= cnt_q;
					dstep_q <= STEP_BITS'(SMP_BITS + 1);
					state_q <= ST_ADIV;
				end
				ST_ADIV: begin
					if (dv_last) state_q <= ST_ADD2;
				end
				ST_ADD2: begin
					mean_q  <= add_mean[SMP_BITS-1:0];
					state_q <= ST_ADD3;
				end
				ST_ADD3: begin
					prod_q  <= (2*SMP_BITS+2)'(mag33(delta_q)) * (2*SMP_BITS+2)'(mag33(d2_add));
					state_q <= ST_ADD4;
				end
				ST_ADD4: begin
					m2_q <= m2_add;
					if (xn_q < mn_q || (!rep_q && cnt_q == CNT_BITS'(1))) mn_q <= xn_q;
					if (xn_q > mx_q || (!rep_q && cnt_q == CNT_BITS'(1))) mx_q <= xn_q;
					state_q <= ST_VAR;
				end

				// reverse welford step
				ST_REM0: begin
					if (cnt_q <= CNT_BITS'(1)) begin
						cnt_q   <= '0;
						mean_q  <= '0;
						m2_q    <= '0;
						state_q <= rep_q ? ST_ADD0 : ST_VAR;
					end else begin
						mc_q    <= (2*SMP_BITS+1)'(mc_w);
						state_q <= ST_REM1;
					end
				end
				ST_REM1: begin
					rneg_q  <= rnum[2*SMP_BITS+1];
					dvd_q   <= {rmag[48:0], 15'd0};
					rem_q   <= '0;
					dsr_q   <= cnt_q - CNT_BITS'(1);
					dstep_q <= STEP_BITS'(49);
					delta_q <= (SMP_BITS+1)'(xo_q) - (SMP_BITS+1)'(mean_q);
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (dv_last) state_q <= ST_REM2;
				end
				ST_REM2: begin
					// clamp the new mean to the sample range
					if (nmw > (2*SMP_BITS+2)'($signed({1'b0, {(SMP_BITS-1){1'b1}}}))) begin
						nm_q <= {1'b0, {(SMP_BITS-1){1'b1}}};
					end else if (nmw < -(2*SMP_BITS+2)'($signed({1'b0, 1'b1,
					                                    {(SMP_BITS-1){1'b0}}}))) begin
						nm_q <= {1'b1, {(SMP_BITS-1){1'b0}}};
					end else begin
						nm_q <= nmw[SMP_BITS-1:0];
					end
					state_q <= ST_REM3;
				end
				ST_REM3: begin
					prod_q  <= (2*SMP_BITS+2)'(mag33(delta_q)) * (2*SMP_BITS+2)'(mag33(d2_rem));
					d2neg_q <= d2_rem[SMP_BITS];
					d2nz_q  <= (d2_rem != '0);
					state_q <= ST_REM4;
				end
				ST_REM4: begin
					m2_q    <= rem_grow ? m2_add : m2_sub;
					mean_q  <= nm_q;
					cnt_q   <= cnt_q - CNT_BITS'(1);
					state_q <= rep_q ? ST_ADD0 : ST_VAR;
				end

				// variance or distinct score
				ST_VAR: begin
					rem_q <= '0;
					if (num_q && cnt_q > CNT_BITS'(1)) begin
						dvd_q   <= {m2_q, 1'b0};
						dsr_q   <= cnt_q - CNT_BITS'(1);
						dstep_q <= STEP_BITS'(SUM_BITS);
						isvar_q <= 1'b1;
						state_q <= ST_ODIV;
					end else if (!num_q && cnt_q != '0) begin
						dvd_q   <= {dist_q, (DVD_BITS-CNT_BITS)'(0)};
						dsr_q   <= cnt_q;
						dstep_q <= STEP_BITS'(2*CNT_BITS);
						isvar_q <= 1'b0;
						state_q <= ST_ODIV;
					end else begin
						res_q   <= '0;
						isvar_q <= 1'b0;
						state_q <= ST_WB;
					end
				end
				ST_ODIV: begin
					if (dv_last) begin
						res_q   <= {dvd_q[SUM_BITS-2:0], dv_ge};
						state_q <= ST_WB;
					end
				end

				// write back and result beat
				ST_WB: begin
					done         <= 1'b1;
					entry_index  <= pos_q;
					sample_total <= cnt_q;
					mean_out     <= mean_q;
					variance_out <= isvar_q ? res_q : '0;
					score_out    <= res_q;
					min_out      <= mn_q;
					max_out      <= mx_q;
					numeric_out  <= num_q;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
